[hdl/ttlkt_pkg.sv]
// Shared types and constants for the keyed lifetime table.
package ttlkt_pkg;

	localparam int ENTRIES      = 16;
	localparam int KEY_BITS     = 16;
	localparam int LIFE_BITS    = 32;
	localparam int PAYLOAD_BITS = 32;

	localparam logic [LIFE_BITS-1:0] LIFE_PERMANENT = '1;

	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_QUERY  = 2'd1;
	localparam logic [1:0] ACT_INSERT = 2'd2;
	localparam logic [1:0] ACT_REMOVE = 2'd3;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_QUERY  = 3'd1,
		OP_INSERT = 3'd2,
		OP_REMOVE = 3'd3,
		OP_FILL   = 3'd4
	} op_t;

	// Request travelling down the row of slots, one slot per cycle.
	// On a scan, free_seen collects whether any slot was empty;
	// on a fill, free_seen marks the request as not yet claimed.
	typedef struct packed {
		logic                    valid;
		op_t                     op;
		logic [KEY_BITS-1:0]     key;
		logic [LIFE_BITS-1:0]    life;
		logic [PAYLOAD_BITS-1:0] data;
		logic                    found;
		logic [PAYLOAD_BITS-1:0] payload;
		logic                    free_seen;
	} tok_t;

endpackage

[hdl/ttlkt_cell.sv]
// One table slot: holds key, lifetime and payload, and acts on the passing request.
module ttlkt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  ttlkt_pkg::tok_t tok_in,
	output ttlkt_pkg::tok_t tok_out
);

	logic                               valid_q;
	logic [ttlkt_pkg::KEY_BITS-1:0]     key_q;
	logic [ttlkt_pkg::LIFE_BITS-1:0]    life_q;
	logic [ttlkt_pkg::PAYLOAD_BITS-1:0] payload_q;
	ttlkt_pkg::tok_t                    tok_q;

	ttlkt_pkg::tok_t                    tok_d;
	logic                               valid_d;
	logic                               write_en;
	logic                               hit;

	assign hit = tok_in.valid && valid_q && (key_q == tok_in.key);

	always_comb begin
		tok_d    = tok_in;
		valid_d  = valid_q;
		write_en = 1'b0;
		if (tok_in.valid) begin
			unique case (tok_in.op)
				ttlkt_pkg::OP_TICK: begin
					if (valid_q && (life_q != ttlkt_pkg::LIFE_PERMANENT)
							&& (life_q[ttlkt_pkg::LIFE_BITS-1:1] == '0)) begin
						valid_d = 1'b0;
					end
				end
				ttlkt_pkg::OP_QUERY: begin
					if (hit) begin
						tok_d.found   = 1'b1;
						tok_d.payload = payload_q;
					end
				end
				ttlkt_pkg::OP_INSERT: begin
					if (!valid_q) begin
						tok_d.free_seen = 1'b1;
					end
					if (hit) begin
						tok_d.found = 1'b1;
						if (tok_in.life == '0) begin
							valid_d = 1'b0;
						end else begin
							write_en = 1'b1;
						end
					end
				end
				ttlkt_pkg::OP_REMOVE: begin
					if (hit) begin
						tok_d.found = 1'b1;
						valid_d     = 1'b0;
					end
				end
				ttlkt_pkg::OP_FILL: begin
					// first empty slot claims the new key
					if (!valid_q && tok_in.free_seen) begin
						tok_d.free_seen = 1'b0;
						valid_d         = 1'b1;
						write_en        = 1'b1;
					end
				end
				default: begin
					tok_d = tok_in;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			valid_q <= valid_d;
			tok_q   <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (write_en) begin
			key_q     <= tok_in.key;
			life_q    <= tok_in.life;
			payload_q <= tok_in.data;
		end else if (tok_in.valid && (tok_in.op == ttlkt_pkg::OP_TICK) && valid_q
				&& (life_q != ttlkt_pkg::LIFE_PERMANENT)) begin
			life_q <= life_q - ttlkt_pkg::LIFE_BITS'(1);
		end
	end

	assign tok_out = tok_q;

endmodule

[hdl/ttl_keyed_table_core.sv]
// Top level of the keyed lifetime table: request injection, row of slots, result register.
//
// Usage: one request enters on in_valid/in_ready (action, entry_key, lifetime,
// payload_in) and one result leaves on out_valid/out_ready (found, payload_out,
// status). A transfer happens on an edge where valid and ready are both high.
// A request walks the row of ENTRIES slot cells, one cell per cycle; each cell
// ages, matches, updates or frees its own entry as the request passes.
// Tick, query, remove and update of a present key need one walk of the row to
// reach out_valid. Insert of a new key needs a second walk that places it in
// the lowest free slot. One request is in the row at a time and the next is
// taken the cycle after its result is loaded.
// in_ready is high only while idle. A finished result is loaded into the
// output register once that is free; while an earlier result still waits on
// out_ready the finished one stays parked and the input stalls. The output
// payload holds while out_valid is high and out_ready is low.
// Reset empties the table at once; no clearing pass is needed.
module ttl_keyed_table_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         action,
	input  logic [ttlkt_pkg::KEY_BITS-1:0]     entry_key,
	input  logic [ttlkt_pkg::LIFE_BITS-1:0]    lifetime,
	input  logic [ttlkt_pkg::PAYLOAD_BITS-1:0] payload_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               found,
	output logic [ttlkt_pkg::PAYLOAD_BITS-1:0] payload_out,
	output logic                               status
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_FILL = 4'b0100,
		ST_HOLD = 4'b1000
	} state_t;

	state_t                             state_q;
	ttlkt_pkg::tok_t                    chain [ttlkt_pkg::ENTRIES+1];
	ttlkt_pkg::tok_t                    tok_new;
	ttlkt_pkg::tok_t                    tok_last;
	ttlkt_pkg::op_t                     op_new;
	logic                               res_found_q;
	logic                               res_status_q;
	logic [ttlkt_pkg::PAYLOAD_BITS-1:0] res_payload_q;
	logic                               out_valid_q;
	logic                               found_q;
	logic                               status_q;
	logic [ttlkt_pkg::PAYLOAD_BITS-1:0] payload_q;
	logic                               in_xfer;
	logic                               need_fill;
	logic                               out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign tok_last = chain[ttlkt_pkg::ENTRIES];
	assign out_free = !out_valid_q || out_ready;
	assign need_fill = (tok_last.op == ttlkt_pkg::OP_INSERT) && !tok_last.found
		&& (tok_last.life != '0);

	always_comb begin
		unique case (action)
			ttlkt_pkg::ACT_TICK:   op_new = ttlkt_pkg::OP_TICK;
			ttlkt_pkg::ACT_QUERY:  op_new = ttlkt_pkg::OP_QUERY;
			ttlkt_pkg::ACT_INSERT: op_new = ttlkt_pkg::OP_INSERT;
			ttlkt_pkg::ACT_REMOVE: op_new = ttlkt_pkg::OP_REMOVE;
			default:               op_new = ttlkt_pkg::OP_TICK;
		endcase
	end

	// inject a fresh request, or send the new key back down to be placed
	always_comb begin
		tok_new = '0;
		if (in_xfer) begin
			tok_new.valid = 1'b1;
			tok_new.op    = op_new;
			tok_new.key   = entry_key;
			tok_new.life  = lifetime;
			tok_new.data  = payload_in;
		end else if ((state_q == ST_SCAN) && tok_last.valid && need_fill
				&& tok_last.free_seen) begin
			tok_new.valid     = 1'b1;
			tok_new.op        = ttlkt_pkg::OP_FILL;
			tok_new.key       = tok_last.key;
			tok_new.life      = tok_last.life;
			tok_new.data      = tok_last.data;
			tok_new.free_seen = 1'b1;
		end
	end

	assign chain[0] = tok_new;

	for (genvar i = 0; i < ttlkt_pkg::ENTRIES; i++) begin : g_cell
		ttlkt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tok_last.valid) begin
						if (need_fill && tok_last.free_seen) begin
							state_q <= ST_FILL;
						end else begin
							state_q <= ST_HOLD;
						end
					end
				end
				ST_FILL: begin
					if (tok_last.valid) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if ((state_q == ST_HOLD) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (((state_q == ST_SCAN) || (state_q == ST_FILL)) && tok_last.valid) begin
			res_found_q   <= tok_last.found;
			res_payload_q <= tok_last.payload;
			if ((state_q == ST_SCAN) && need_fill && !tok_last.free_seen) begin
				res_status_q <= ttlkt_pkg::STATUS_FULL;
			end else begin
				res_status_q <= ttlkt_pkg::STATUS_DONE;
			end
		end
		if ((state_q == ST_HOLD) && out_free) begin
			found_q   <= res_found_q;
			payload_q <= res_payload_q;
			status_q  <= res_status_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign payload_out = payload_q;
	assign status      = status_q;

endmodule
